// ===== hdl/sact_pkg.sv =====
// Shared types and constants for the set-associative cache tag block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sact_pkg;

    // Default sizes of the tag store and the address
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 32;

    // Widths of the configuration registers
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 4;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int KIND_W       = 2;

    // Access kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2
    } kind_e;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_e;

    // Current configuration, as held by the top level
    typedef struct packed {
        logic [SET_BITS_W-1:0]   set_bits;
        logic [BLOCK_BITS_W-1:0] block_bits;
        logic [WAYS_W-1:0]       ways;
    } cfg_t;

    // Outcome of one lookup
    typedef struct packed {
        logic hit;
        logic evicted;
    } lookup_res_t;

endpackage

`default_nettype wire

// ===== hdl/sact_split.sv =====
// Address split: derives the set index and tag of an access from the configuration.
// Depends on sact_pkg (cfg_t).
`default_nettype none

module sact_split
    import sact_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    localparam int SET_IW      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
)
(
    input  var cfg_t                 cfg,
    input  wire logic [ADDR_BITS-1:0] address,
    output logic      [SET_IW-1:0]    set_idx,
    output logic      [ADDR_BITS-1:0] tag
);

    localparam int SB_W    = 4;
    localparam int SHIFT_W = 6;

    logic [SB_W-1:0]    sb;
    logic [SET_IW-1:0]  set_mask;
    logic [SHIFT_W-1:0] tag_shift;
    logic [ADDR_BITS-1:0] shifted;

    // Saturate the set bit count to the store size
    always_comb
    begin
        if (32'(cfg.set_bits) > MAX_SET_BITS)
            sb = SB_W'(MAX_SET_BITS);
        else
            sb = SB_W'(cfg.set_bits);
    end

    // Shift away the block offset, keep the low set bits as index
    assign set_mask  = SET_IW'((64'd1 << sb) - 64'd1);
    assign shifted   = address >> cfg.block_bits;
    assign set_idx   = SET_IW'(shifted) & set_mask;
    assign tag_shift = SHIFT_W'(cfg.block_bits) + SHIFT_W'(sb);
    assign tag       = address >> tag_shift;

endmodule

`default_nettype wire

// ===== hdl/sact_lookup.sv =====
// Tag compare and FIFO victim choice for one set row read from the store.
// Depends on sact_pkg (lookup_res_t).
`default_nettype none

module sact_lookup
    import sact_pkg::*;
#(
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int CNT_W    = $clog2(MAX_WAYS + 1)
)
(
    input  wire logic [CNT_W-1:0]                  nw,
    input  wire logic                              set_valid,
    input  wire logic [CNT_W-1:0]                  rd_fill,
    input  wire logic [WAY_W-1:0]                  rd_fifo,
    input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_row,
    input  wire logic [ADDR_BITS-1:0]              tag,
    output lookup_res_t                            res,
    output logic [CNT_W-1:0]                       wr_fill,
    output logic [WAY_W-1:0]                       wr_fifo,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]     wr_row
);

    logic [CNT_W-1:0]    fill_eff;
    logic [WAY_W-1:0]    fifo_eff;
    logic [MAX_WAYS-1:0] match;
    logic                full;
    logic [WAY_W-1:0]    victim;
    logic [CNT_W-1:0]    victim_inc;

    // Treat a set flushed since its last fill as empty
    always_comb
    begin
        if (!set_valid)
            fill_eff = '0;
        else if (rd_fill > nw)
            fill_eff = nw;
        else
            fill_eff = rd_fill;
        fifo_eff = set_valid ? rd_fifo : '0;
    end

    // Compare the tag against every held line of the set
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
            match[w] = (CNT_W'(w) < fill_eff) && (rd_row[w] == tag);
    end

    // Pick the victim: next free way, else the oldest line
    always_comb
    begin
        full = (fill_eff >= nw);
        if (!full)
            victim = WAY_W'(fill_eff);
        else if (CNT_W'(fifo_eff) >= nw)
            victim = '0;
        else
            victim = fifo_eff;
        victim_inc = CNT_W'(victim) + CNT_W'(1);
    end

    // Build the updated set state and row
    always_comb
    begin
        res.hit     = |match;
        res.evicted = !res.hit && full;
        if (full)
        begin
            wr_fill = fill_eff;
            wr_fifo = (victim_inc >= nw) ? '0 : WAY_W'(victim_inc);
        end
        else
        begin
            wr_fill = fill_eff + CNT_W'(1);
            wr_fifo = fifo_eff;
        end
        for (int w = 0; w < MAX_WAYS; w++)
            wr_row[w] = (WAY_W'(w) == victim) ? tag : rd_row[w];
    end

endmodule

`default_nettype wire

// ===== hdl/sact_store.sv =====
// Tag row memory and set state memory with registered reads, write forwarding
// and per-set valid bits for flushing. Depends on sact_pkg (defaults).
`default_nettype none

module sact_store
    import sact_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    localparam int SET_IW      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int NUM_SETS    = 1 << MAX_SET_BITS,
    localparam int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int CNT_W       = $clog2(MAX_WAYS + 1)
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               flush,
    input  wire logic                               rd_en,
    input  wire logic [SET_IW-1:0]                  rd_set,
    output logic      [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_row_reg,
    output logic      [CNT_W-1:0]                   rd_fill_reg,
    output logic      [WAY_W-1:0]                   rd_fifo_reg,
    input  wire logic [SET_IW-1:0]                  sv_set,
    output logic                                    sv,
    input  wire logic                               wr_en,
    input  wire logic [SET_IW-1:0]                  wr_set,
    input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0] wr_row,
    input  wire logic [CNT_W-1:0]                   wr_fill,
    input  wire logic [WAY_W-1:0]                   wr_fifo
);

    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [NUM_SETS];
    logic [CNT_W+WAY_W-1:0]             state_mem [NUM_SETS];
    logic [NUM_SETS-1:0]                set_valid_reg;
    logic                               fwd;

    // Forward a row written in the same cycle it is read
    assign fwd = wr_en && (wr_set == rd_set);

    // Write the row and set state back
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_set]   <= wr_row;
            state_mem[wr_set] <= {wr_fill, wr_fifo};
        end
    end

    // Read the row and set state, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (fwd)
            begin
                rd_row_reg  <= wr_row;
                rd_fill_reg <= wr_fill;
                rd_fifo_reg <= wr_fifo;
            end
            else
            begin
                rd_row_reg                 <= tag_mem[rd_set];
                {rd_fill_reg, rd_fifo_reg} <= state_mem[rd_set];
            end
        end
    end

    // Mark sets written since the last flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_valid_reg <= '0;
        else if (flush)
            set_valid_reg <= '0;
        else if (wr_en)
            set_valid_reg[wr_set] <= 1'b1;
    end

    assign sv = set_valid_reg[sv_set];

endmodule

`default_nettype wire

// ===== hdl/set_assoc_cache_tag_sim.sv =====
// Set-associative cache tag lookup with FIFO replacement. One access request
// is taken per cycle when results are taken as fast. An accepted request reads
// the set row into the lookup stage; when that stage advances, it compares,
// writes back and loads the output register. The rate is set by the tag row
// read-modify-write on a memory pair with one read and one write per cycle,
// with the row being written forwarded to a read of the same set. Reset and
// any write to a known configuration register clears per-set valid flops at
// once, so there is no clearing pass. A modify access reports second_hit
// high, since its second access always hits.
// Depends on sact_pkg, sact_split, sact_lookup and sact_store.
`default_nettype none

module set_assoc_cache_tag_sim
    import sact_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [KIND_W-1:0]      kind,
    input  wire logic [ADDR_BITS-1:0]   address,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        hit,
    output logic                        evicted,
    output logic                        second_hit,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);

    cfg_t                               cfg_reg;
    logic                               flush;
    logic                               accept;
    logic                               s1_adv;
    logic [CNT_W-1:0]                   nw;
    logic [SET_IW-1:0]                  in_set;
    logic [ADDR_BITS-1:0]               in_tag;
    logic                               s1_valid_reg;
    logic                               s1_modify_reg;
    logic [SET_IW-1:0]                  s1_set_reg;
    logic [ADDR_BITS-1:0]               s1_tag_reg;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_row;
    logic [CNT_W-1:0]                   rd_fill;
    logic [WAY_W-1:0]                   rd_fifo;
    logic                               sv;
    lookup_res_t                        lk_res;
    logic [CNT_W-1:0]                   wr_fill;
    logic [WAY_W-1:0]                   wr_fifo;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] wr_row;
    logic                               out_valid_reg;
    lookup_res_t                        out_res_reg;
    logic                               out_second_reg;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign accept    = in_valid && in_ready;

    // Flush the store on any write to a known register
    always_comb
    begin
        flush = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SET_BITS,
                CFG_BLOCK_BITS,
                CFG_WAYS: flush = 1'b1;
                default:  flush = 1'b0;
            endcase
        end
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits   <= '0;
            cfg_reg.block_bits <= '0;
            cfg_reg.ways       <= WAYS_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   cfg_reg.set_bits   <= cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: cfg_reg.block_bits <= cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       cfg_reg.ways       <= cfg_data[WAYS_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Clamp the way count to 1..MAX_WAYS
    always_comb
    begin
        if (cfg_reg.ways == '0)
            nw = CNT_W'(1);
        else if (32'(cfg_reg.ways) > MAX_WAYS)
            nw = CNT_W'(MAX_WAYS);
        else
            nw = CNT_W'(cfg_reg.ways);
    end

    sact_split #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_split (
        .cfg     (cfg_reg),
        .address (address),
        .set_idx (in_set),
        .tag     (in_tag)
    );

    sact_store #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .flush       (flush),
        .rd_en       (accept),
        .rd_set      (in_set),
        .rd_row_reg  (rd_row),
        .rd_fill_reg (rd_fill),
        .rd_fifo_reg (rd_fifo),
        .sv_set      (s1_set_reg),
        .sv          (sv),
        .wr_en       (s1_adv && !lk_res.hit),
        .wr_set      (s1_set_reg),
        .wr_row      (wr_row),
        .wr_fill     (wr_fill),
        .wr_fifo     (wr_fifo)
    );

    sact_lookup #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lookup (
        .nw        (nw),
        .set_valid (sv),
        .rd_fill   (rd_fill),
        .rd_fifo   (rd_fifo),
        .rd_row    (rd_row),
        .tag       (s1_tag_reg),
        .res       (lk_res),
        .wr_fill   (wr_fill),
        .wr_fifo   (wr_fifo),
        .wr_row    (wr_row)
    );

    // Advance the lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_modify_reg <= (kind == KIND_MODIFY);
            s1_set_reg    <= in_set;
            s1_tag_reg    <= in_tag;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_res_reg    <= lk_res;
            out_second_reg <= s1_modify_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_res_reg.hit;
    assign evicted    = out_res_reg.evicted;
    assign second_hit = out_second_reg;

endmodule

`default_nettype wire

// ===== hdl/sact_checker.sv =====
// Port-level checks for set_assoc_cache_tag_sim, and the bind that attaches them.
// Depends on sact_pkg and the top level's port list.
`default_nettype none

module sact_checker
    import sact_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic hit,
    input wire logic evicted,
    input wire logic second_hit
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(evicted)
            && $stable(second_hit))
        else $error("result changed while stalled");

    // An eviction only follows a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("eviction reported on a hit");

    // Requests are refused only behind a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused without a stalled result");

    // An accepted request is followed by a valid result at the output, after the lookup stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("accepted request produced no result");

endmodule

bind set_assoc_cache_tag_sim sact_checker u_sact_checker (.*);

`default_nettype wire

// ===== tb/sv/set_assoc_cache_tag_sim_tb.sv =====
// Self-checking testbench for set_assoc_cache_tag_sim: directed and random cache
// accesses under several tag-store settings, checked against a FIFO-replacement model.
// Depends on sact_pkg and the set_assoc_cache_tag_sim RTL.
`default_nettype none

module set_assoc_cache_tag_sim_tb
    import sact_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = DEF_ADDR_BITS;
    localparam int SB_MAX      = DEF_MAX_SET_BITS;
    localparam int WAYS_MAX    = DEF_MAX_WAYS;
    localparam int NUM_SETS    = 1 << SB_MAX;
    localparam int NUM_LINES   = NUM_SETS * WAYS_MAX;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 118;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Codes outside the package enums
    localparam logic [KIND_W-1:0]      KIND_RSVD  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic hit;
        logic evicted;
        logic second_hit;
    } outcome_t;

    // Tag store model plus the queue of outcomes still owed by the block
    class cache_tag_checker;
        logic [ADDR_W-1:0]       line_tag [NUM_LINES];
        bit                      line_valid [NUM_LINES];
        int unsigned             set_fill [NUM_SETS];
        int unsigned             oldest_way [NUM_SETS];
        logic [SET_BITS_W-1:0]   set_bits;
        logic [BLOCK_BITS_W-1:0] block_bits;
        logic [WAYS_W-1:0]       ways;
        outcome_t                owed_outcomes [$];
        int                      mismatches;

        function new();
            mismatches = 0;
            set_bits   = '0;
            block_bits = '0;
            ways       = WAYS_W'(1);
            invalidate_all();
        endfunction

        function void invalidate_all();
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
            foreach (set_fill[i])
            begin
                set_fill[i]   = 0;
                oldest_way[i] = 0;
            end
        endfunction

        // Any known register write also drops every line
        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits   = data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits = data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       ways       = data[WAYS_W-1:0];
                default:        return;
            endcase
            invalidate_all();
        endfunction

        // Look up one access, update the set and queue the outcome
        function void note_access(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a);
            int unsigned       sb;
            int unsigned       nw;
            int unsigned       set_i;
            int unsigned       base;
            int unsigned       fill;
            int unsigned       victim;
            int unsigned       w;
            logic [63:0]       wide;
            logic [ADDR_W-1:0] tag;
            outcome_t          o;
            sb = (set_bits > SB_MAX) ? SB_MAX : set_bits;
            nw = ways;
            if (nw < 1)
                nw = 1;
            if (nw > WAYS_MAX)
                nw = WAYS_MAX;
            wide  = {32'd0, a};
            set_i = int'((wide >> block_bits) & ((64'd1 << sb) - 64'd1));
            tag   = ADDR_W'(wide >> (block_bits + sb));
            base  = set_i * WAYS_MAX;
            fill  = set_fill[set_i];
            if (fill > nw)
                fill = nw;
            o = '0;
            for (w = 0; w < fill; w++)
            begin
                if (line_valid[base + w] && line_tag[base + w] == tag)
                begin
                    o.hit = 1'b1;
                    break;
                end
            end
            // Miss: take a free way, or replace the oldest line of a full set
            if (!o.hit)
            begin
                if (fill >= nw)
                begin
                    victim = oldest_way[set_i];
                    if (victim >= nw)
                        victim = 0;
                    o.evicted = 1'b1;
                    oldest_way[set_i] = (victim + 1 >= nw) ? 0 : victim + 1;
                end
                else
                begin
                    victim = fill;
                    set_fill[set_i] = fill + 1;
                end
                line_tag[base + victim]   = tag;
                line_valid[base + victim] = 1'b1;
            end
            o.second_hit = (k == KIND_MODIFY);
            owed_outcomes.push_back(o);
        endfunction

        function void check_result(logic h, logic e, logic s);
            outcome_t want;
            if (owed_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: hit %0b evicted %0b second_hit %0b",
                       h, e, s);
                mismatches++;
                return;
            end
            want = owed_outcomes.pop_front();
            if (h !== want.hit)
            begin
                $error("hit mismatch: expected %0b, actual %0b", want.hit, h);
                mismatches++;
            end
            if (e !== want.evicted)
            begin
                $error("evicted mismatch: expected %0b, actual %0b", want.evicted, e);
                mismatches++;
            end
            if (s !== want.second_hit)
            begin
                $error("second_hit mismatch: expected %0b, actual %0b", want.second_hit, s);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed_outcomes.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind;
    logic [ADDR_W-1:0]      address;
    logic                   out_valid;
    logic                   out_ready;
    logic                   hit;
    logic                   evicted;
    logic                   second_hit;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cache_tag_checker tag_check;
    int unsigned      requests_sent;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      cycle_count;

    // Settings of the random phases, extremes included
    int unsigned phase_set_bits   [NUM_PHASES] = '{3, 0, 6, 7, 2, 5, 1};
    int unsigned phase_block_bits [NUM_PHASES] = '{4, 0, 20, 31, 10, 26, 2};
    int unsigned phase_ways       [NUM_PHASES] = '{4, 1, 8, 0, 2, 15, 3};

    set_assoc_cache_tag_sim i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .evicted    (evicted),
        .second_hit (second_hit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result side at the current rate
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tag_check.check_result(hit, evicted, second_hit);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pick idling rates from progress: sender light, then receiver light, then none
    function automatic void update_idling();
        if (requests_sent < 290)
        begin
            send_idle_pct  = 6;
            recv_stall_pct = 47;
        end
        else if (requests_sent < 580)
        begin
            send_idle_pct  = 47;
            recv_stall_pct = 6;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endfunction

    task automatic send_access(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        address  <= a;
        do
            @(posedge clk);
        while (!in_ready);
        tag_check.note_access(k, a);
        requests_sent++;
        update_idling();
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain(int unsigned settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (tag_check.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain(4);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tag_check.write_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly reuse a few tags in a few sets so hits and evictions happen; some noise
    function automatic logic [ADDR_W-1:0] pick_address(int unsigned sb, int unsigned bb,
                                                       int unsigned nw, logic [ADDR_W-1:0] salt);
        logic [63:0] tag;
        logic [63:0] set_i;
        logic [63:0] ofs;
        logic [63:0] wide;
        if ($urandom_range(99) < 12)
            return ADDR_W'($urandom);
        tag   = {32'd0, salt} + 64'($urandom_range(0, nw + 2));
        set_i = 64'($urandom_range(0, 3));
        ofs   = {$urandom, $urandom};
        wide  = (tag << (bb + sb)) | ((set_i & ((64'd1 << sb) - 64'd1)) << bb)
              | (ofs & ((64'd1 << bb) - 64'd1));
        return wide[ADDR_W-1:0];
    endfunction

    initial
    begin
        int unsigned       sb;
        int unsigned       nw;
        logic [ADDR_W-1:0] salt;
        tag_check     = new();
        requests_sent = 0;
        cycle_count   = 0;
        update_idling();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_LOAD;
        address   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: one set, one way, no offset
        send_access(KIND_LOAD, 32'h0000_0000);
        send_access(KIND_STORE, 32'h0000_0000);
        send_access(KIND_MODIFY, 32'hffff_ffff);
        send_access(KIND_RSVD, 32'hffff_ffff);
        send_access(KIND_LOAD, 32'h0000_0000);

        // Oversized set count, large offset, zero ways: every tag is zero, the top address bit picks the set
        write_register(CFG_SET_BITS, 5'd7);
        write_register(CFG_BLOCK_BITS, 5'd31);
        write_register(CFG_WAYS, 5'd0);
        send_access(KIND_LOAD, 32'hffff_ffff);
        send_access(KIND_STORE, 32'h0000_0000);

        // Unknown register index keeps the lines
        write_register(CFG_UNUSED, 5'd31);
        send_access(KIND_MODIFY, 32'h1234_5678);

        // Ways above the maximum clamp to eight; fill a set, evict oldest, hit without reorder
        write_register(CFG_SET_BITS, 5'd0);
        write_register(CFG_BLOCK_BITS, 5'd0);
        write_register(CFG_WAYS, 5'd15);
        for (int i = 0; i < 9; i++)
            send_access(KIND_LOAD, ADDR_W'(i));
        send_access(KIND_LOAD, 32'd1);
        send_access(KIND_STORE, 32'd0);

        // Random phases, one setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(CFG_SET_BITS, CFG_DATA_W'(phase_set_bits[p]));
            write_register(CFG_BLOCK_BITS, CFG_DATA_W'(phase_block_bits[p]));
            write_register(CFG_WAYS, CFG_DATA_W'(phase_ways[p]));
            if (p == 4)
                write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
            sb = (phase_set_bits[p] > SB_MAX) ? SB_MAX : phase_set_bits[p];
            nw = phase_ways[p];
            if (nw < 1)
                nw = 1;
            if (nw > WAYS_MAX)
                nw = WAYS_MAX;
            salt = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_access(KIND_W'($urandom_range(0, 3)),
                            pick_address(sb, phase_block_bits[p], nw, salt));
        end

        drain(SETTLE);
        if (tag_check.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
